FILE: sv/tmpc_pkg.sv
// Shared types, constants and helper functions for the track motor PWM
// command controller. No dependencies; every other file imports it.
`timescale 1ns / 1ps

package tmpc_pkg;

    // Field widths
    localparam int CHAR_W   = 8;
    localparam int VALUE_W  = 16;
    localparam int PERIOD_W = 16;
    localparam int SPEED_W  = 8;
    localparam int THRUST_W = 12;
    localparam int TRACKS   = 4;
    localparam int PROD_W   = PERIOD_W + SPEED_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Operation codes
    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_COMMAND = 1'b1;

    // Command characters (upper case)
    localparam logic [CHAR_W-1:0] CH_W = 8'h57;
    localparam logic [CHAR_W-1:0] CH_T = 8'h54;
    localparam logic [CHAR_W-1:0] CH_U = 8'h55;
    localparam logic [CHAR_W-1:0] CH_F = 8'h46;
    localparam logic [CHAR_W-1:0] CH_B = 8'h42;
    localparam logic [CHAR_W-1:0] CH_L = 8'h4C;
    localparam logic [CHAR_W-1:0] CH_R = 8'h52;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PWM_PERIOD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_SPEED  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FAST_SPEED  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THRUST_STOP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_THRUST_MAX  = 3'd4;

    // Reset values
    localparam logic [PERIOD_W-1:0] PERIOD_RST      = 16'd2000;
    localparam logic [SPEED_W-1:0]  SLOW_RST        = 8'd40;
    localparam logic [SPEED_W-1:0]  FAST_RST        = 8'd128;
    localparam logic [THRUST_W-1:0] THRUST_STOP_RST = 12'd1050;
    localparam logic [THRUST_W-1:0] THRUST_MAX_RST  = 12'd2000;
    localparam logic [SPEED_W-1:0]  DUTY_FULL       = 8'd255;

    // One input request after the input register
    typedef struct packed {
        logic                      operation;
        logic [CHAR_W-1:0]         cmd_type;
        logic [CHAR_W-1:0]         cmd_direction;
        logic                      values_present;
        logic signed [VALUE_W-1:0] left_value;
        logic signed [VALUE_W-1:0] right_value;
    } t_item;

    // State updates decoded from one request
    typedef struct packed {
        logic                             is_tick;
        logic                             known;
        logic                             thr_wr;
        logic                             thr_active;
        logic [THRUST_W-1:0]              left_thrust;
        logic [THRUST_W-1:0]              right_thrust;
        logic                             trk_wr;
        logic                             trk_active;
        logic [TRACKS-1:0][SPEED_W-1:0]   speed;
        logic                             fwd_wr;
        logic                             fwd_val;
        logic                             led_wr;
        logic                             led_val;
    } t_cmd_upd;

    // Fold lower-case letters to upper case
    function automatic logic [CHAR_W-1:0] upcase(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] v;
        v = c;
        if (c >= 8'h61 && c <= 8'h7A) begin
            v = c - 8'd32;
        end
        return v;
    endfunction

    // Floor of x / 255: shift-add estimate, then one remainder correction
    function automatic logic [PERIOD_W-1:0] div255(input logic [PROD_W-1:0] x);
        logic [PROD_W+1:0] xe;
        logic [PROD_W+1:0] sum;
        logic [PROD_W+1:0] q0;
        logic [PROD_W+1:0] prod;
        logic [PROD_W+1:0] rem;
        logic [PROD_W+1:0] q;
        xe   = {2'b00, x};
        sum  = xe + (xe >> 8) + (xe >> 16);
        q0   = sum >> 8;
        prod = (q0 << 8) - q0;
        rem  = xe - prod;
        q    = (rem >= (PROD_W+2)'(DUTY_FULL)) ? q0 + (PROD_W+2)'(1) : q0;
        return q[PERIOD_W-1:0];
    endfunction

endpackage

FILE: sv/tmpc_cmd_decode.sv
// Command decoder: turns one registered request into state updates.
// Depends on tmpc_pkg for the request and update types.
`timescale 1ns / 1ps

module tmpc_cmd_decode
    import tmpc_pkg::*;
(
    input  t_item                i_item,
    input  logic [SPEED_W-1:0]   i_slow_speed,
    input  logic [SPEED_W-1:0]   i_fast_speed,
    input  logic [THRUST_W-1:0]  i_thrust_stop,
    input  logic [THRUST_W-1:0]  i_thrust_max,
    output t_cmd_upd             o_upd
);

    logic [CHAR_W-1:0]  typ;
    logic [CHAR_W-1:0]  dir;
    logic [SPEED_W-1:0] sp;

    // Raise to the stop value first, then cap at the max value
    function automatic logic [THRUST_W-1:0] clamp_thrust(
        input logic signed [VALUE_W-1:0] v,
        input logic [THRUST_W-1:0]       lo,
        input logic [THRUST_W-1:0]       hi
    );
        logic signed [VALUE_W:0] w;
        logic signed [VALUE_W:0] lo_s;
        logic signed [VALUE_W:0] hi_s;
        w    = {v[VALUE_W-1], v};
        lo_s = signed'({{(VALUE_W+1-THRUST_W){1'b0}}, lo});
        hi_s = signed'({{(VALUE_W+1-THRUST_W){1'b0}}, hi});
        if (w < lo_s) begin
            w = lo_s;
        end
        if (w > hi_s) begin
            w = hi_s;
        end
        return w[THRUST_W-1:0];
    endfunction

    assign typ = upcase(i_item.cmd_type);
    assign dir = upcase(i_item.cmd_direction);
    assign sp  = (typ == CH_U) ? i_fast_speed : i_slow_speed;

    // Decode the request into register updates
    always_comb begin
        o_upd = '0;
        if (i_item.operation == OP_TICK) begin
            o_upd.is_tick = 1'b1;
        end else if (typ == CH_W) begin
            o_upd.known  = 1'b1;
            o_upd.thr_wr = 1'b1;
            o_upd.led_wr = 1'b1;
            case (dir)
                CH_F: begin
                    if (i_item.values_present) begin
                        o_upd.left_thrust  = clamp_thrust(i_item.left_value,
                                                          i_thrust_stop, i_thrust_max);
                        o_upd.right_thrust = clamp_thrust(i_item.right_value,
                                                          i_thrust_stop, i_thrust_max);
                    end else begin
                        o_upd.left_thrust  = i_thrust_max;
                        o_upd.right_thrust = i_thrust_max;
                    end
                    o_upd.thr_active = 1'b1;
                    o_upd.led_val    = 1'b1;
                end
                CH_L: begin
                    o_upd.left_thrust  = i_thrust_stop;
                    o_upd.right_thrust = i_thrust_max;
                    o_upd.thr_active   = 1'b1;
                    o_upd.led_val      = 1'b1;
                end
                CH_R: begin
                    o_upd.left_thrust  = i_thrust_max;
                    o_upd.right_thrust = i_thrust_stop;
                    o_upd.thr_active   = 1'b1;
                    o_upd.led_val      = 1'b1;
                end
                default: begin
                    o_upd.left_thrust  = i_thrust_stop;
                    o_upd.right_thrust = i_thrust_stop;
                end
            endcase
        end else if (typ == CH_T || typ == CH_U) begin
            o_upd.known      = 1'b1;
            o_upd.trk_wr     = 1'b1;
            o_upd.trk_active = 1'b1;
            o_upd.led_wr     = 1'b1;
            o_upd.led_val    = 1'b1;
            o_upd.fwd_wr     = 1'b1;
            case (dir)
                CH_F: begin
                    o_upd.speed   = {sp, sp, sp, sp};
                    o_upd.fwd_val = 1'b1;
                end
                CH_B: begin
                    o_upd.speed   = {sp, sp, sp, sp};
                end
                CH_L: begin
                    // slow on the left tracks (0 and 2)
                    o_upd.speed   = {sp, i_slow_speed, sp, i_slow_speed};
                    o_upd.fwd_val = 1'b1;
                end
                CH_R: begin
                    // slow on the right tracks (1 and 3)
                    o_upd.speed   = {i_slow_speed, sp, i_slow_speed, sp};
                    o_upd.fwd_val = 1'b1;
                end
                default: begin
                    // stop: speeds to zero, keep directions
                    o_upd.fwd_wr     = 1'b0;
                    o_upd.trk_active = 1'b0;
                    o_upd.led_val    = 1'b0;
                end
            endcase
        end
    end

endmodule

FILE: sv/tmpc_pwm_lane.sv
// One track PWM channel: speed, level, elapsed counter and high/low times.
// Depends on tmpc_pkg for widths and the divide-by-255 helper.
`timescale 1ns / 1ps

module tmpc_pwm_lane
    import tmpc_pkg::*;
#(
    parameter int COUNTER_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_set_speed,
    input  logic [SPEED_W-1:0]  i_speed,
    input  logic                i_tick,
    input  logic [PERIOD_W-1:0] i_period,
    output logic                o_level_next
);

    localparam int CW = (COUNTER_BITS > PERIOD_W) ? COUNTER_BITS : PERIOD_W;

    logic [SPEED_W-1:0]      r_speed, n_speed;
    logic                    r_level, n_level;
    logic [COUNTER_BITS-1:0] r_count, n_count;
    logic [PERIOD_W-1:0]     r_high, n_high;
    logic [PERIOD_W-1:0]     r_low, n_low;
    logic [PROD_W-1:0]       product;
    logic [COUNTER_BITS-1:0] count_inc;

    // Refresh high/low times from the speed that will be stored
    always_comb begin
        n_speed = i_set_speed ? i_speed : r_speed;
        product = PROD_W'(i_period) * PROD_W'(n_speed);
        n_high  = div255(product);
        n_low   = i_period - n_high;
    end

    assign count_inc = (&r_count) ? r_count : r_count + COUNTER_BITS'(1);

    // Advance the channel on a tick
    always_comb begin
        n_level = r_level;
        n_count = r_count;
        if (i_tick) begin
            if (r_speed == '0) begin
                n_level = 1'b0;
                n_count = '0;
            end else begin
                n_count = count_inc;
                if (!r_level && CW'(n_count) >= CW'(r_low)) begin
                    n_level = 1'b1;
                    n_count = '0;
                end
                if (n_level && CW'(n_count) >= CW'(r_high)) begin
                    n_level = 1'b0;
                    n_count = '0;
                end
            end
        end
    end

    assign o_level_next = n_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed <= '0;
            r_level <= 1'b0;
            r_count <= '0;
        end else begin
            r_speed <= n_speed;
            r_level <= n_level;
            r_count <= n_count;
        end
    end

    // Timing values follow the speed and period every cycle
    always_ff @(posedge i_clk) begin
        r_high <= n_high;
        r_low  <= n_low;
    end

endmodule

FILE: sv/track_motor_pwm_command_controller.sv
// Top level of the track motor PWM command controller: registers, request
// pipeline and result register. Depends on tmpc_pkg, tmpc_cmd_decode, tmpc_pwm_lane.
`timescale 1ns / 1ps

// Usage:
// Requests enter on the s_axis channel; tuser[0] selects a tick (0) or a
// command (1). Each request yields exactly one result on m_axis showing the
// PWM levels, directions, thruster pulse widths and flags after that request.
// Configuration writes go through i_cfg_valid/i_cfg_index/i_cfg_data and are
// always taken (o_cfg_ready is high); write only while no request is in flight.
// An accepted request waits in the input register, then moves to the result
// register. Throughput: one request per cycle while results are taken, set by
// the single decode/update stage and the per-channel high-time multiply in that stage.
// A receiver stall holds the result register; the input register then fills
// and s_axis_tready drops until the result is taken. No request is lost.
// Reset (synchronous, active low) loads the register defaults, stops all
// tracks and thrusters and empties both pipeline registers.
module track_motor_pwm_command_controller
    import tmpc_pkg::*;
#(
    parameter int COUNTER_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request channel
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [7:0] cmd_type, [15:8] cmd_direction, [31:16] left_value, [47:32] right_value
    input  logic [47:0]           s_axis_tdata,
    // [0] operation, [1] values_present
    input  logic [1:0]            s_axis_tuser,
    // result channel
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [3:0] pwm_levels, [7:4] forward_bits, [19:8] left_pulse, [31:20] right_pulse,
    // [32] thrusters_on, [33] tracks_on, [34] led_on, [39:35] zero
    output logic [39:0]           m_axis_tdata,
    // [0] command_known
    output logic [0:0]            m_axis_tuser,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Configuration registers
    logic [PERIOD_W-1:0] r_pwm_period;
    logic [SPEED_W-1:0]  r_slow_speed;
    logic [SPEED_W-1:0]  r_fast_speed;
    logic [THRUST_W-1:0] r_thrust_stop;
    logic [THRUST_W-1:0] r_thrust_max;

    // Pipeline registers
    logic                r_in_valid;
    t_item               r_in;
    logic                r_out_valid;
    logic [39:0]         r_out_data;
    logic                r_out_known;

    // Controller state
    logic [TRACKS-1:0]   r_forward, n_forward;
    logic [THRUST_W-1:0] r_left_thrust, n_left_thrust;
    logic [THRUST_W-1:0] r_right_thrust, n_right_thrust;
    logic                r_thr_active, n_thr_active;
    logic                r_trk_active, n_trk_active;
    logic                r_led, n_led;

    logic                out_free;
    logic                exec;
    t_cmd_upd            upd;
    logic [TRACKS-1:0]   level_next;
    logic [THRUST_W-1:0] left_pulse;
    logic [THRUST_W-1:0] right_pulse;

    assign o_cfg_ready   = 1'b1;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign exec          = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pwm_period  <= PERIOD_RST;
            r_slow_speed  <= SLOW_RST;
            r_fast_speed  <= FAST_RST;
            r_thrust_stop <= THRUST_STOP_RST;
            r_thrust_max  <= THRUST_MAX_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_PWM_PERIOD:  r_pwm_period  <= i_cfg_data[PERIOD_W-1:0];
                REG_SLOW_SPEED:  r_slow_speed  <= i_cfg_data[SPEED_W-1:0];
                REG_FAST_SPEED:  r_fast_speed  <= i_cfg_data[SPEED_W-1:0];
                REG_THRUST_STOP: r_thrust_stop <= i_cfg_data[THRUST_W-1:0];
                REG_THRUST_MAX:  r_thrust_max  <= i_cfg_data[THRUST_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register: hold the request until it executes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in.operation      <= s_axis_tuser[0];
            r_in.values_present <= s_axis_tuser[1];
            r_in.cmd_type       <= s_axis_tdata[7:0];
            r_in.cmd_direction  <= s_axis_tdata[15:8];
            r_in.left_value     <= signed'(s_axis_tdata[31:16]);
            r_in.right_value    <= signed'(s_axis_tdata[47:32]);
        end
    end

    tmpc_cmd_decode u_decode (
        .i_item        (r_in),
        .i_slow_speed  (r_slow_speed),
        .i_fast_speed  (r_fast_speed),
        .i_thrust_stop (r_thrust_stop),
        .i_thrust_max  (r_thrust_max),
        .o_upd         (upd)
    );

    // Track channels
    for (genvar g = 0; g < TRACKS; g++) begin : g_lane
        tmpc_pwm_lane #(
            .COUNTER_BITS (COUNTER_BITS)
        ) u_lane (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_set_speed  (exec && upd.trk_wr),
            .i_speed      (upd.speed[g]),
            .i_tick       (exec && upd.is_tick),
            .i_period     (r_pwm_period),
            .o_level_next (level_next[g])
        );
    end

    // Next controller state
    always_comb begin
        n_forward      = r_forward;
        n_left_thrust  = r_left_thrust;
        n_right_thrust = r_right_thrust;
        n_thr_active   = r_thr_active;
        n_trk_active   = r_trk_active;
        n_led          = r_led;
        if (exec) begin
            if (upd.fwd_wr) begin
                n_forward = {TRACKS{upd.fwd_val}};
            end
            if (upd.thr_wr) begin
                n_left_thrust  = upd.left_thrust;
                n_right_thrust = upd.right_thrust;
                n_thr_active   = upd.thr_active;
            end
            if (upd.trk_wr) begin
                n_trk_active = upd.trk_active;
            end
            if (upd.led_wr) begin
                n_led = upd.led_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_forward      <= '1;
            r_left_thrust  <= THRUST_STOP_RST;
            r_right_thrust <= THRUST_STOP_RST;
            r_thr_active   <= 1'b0;
            r_trk_active   <= 1'b0;
            r_led          <= 1'b0;
        end else begin
            r_forward      <= n_forward;
            r_left_thrust  <= n_left_thrust;
            r_right_thrust <= n_right_thrust;
            r_thr_active   <= n_thr_active;
            r_trk_active   <= n_trk_active;
            r_led          <= n_led;
        end
    end

    // Pulse widths fall back to the stop value while thrusters are off
    assign left_pulse  = n_thr_active ? n_left_thrust : r_thrust_stop;
    assign right_pulse = n_thr_active ? n_right_thrust : r_thrust_stop;

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec) begin
            r_out_data  <= {5'd0, n_led, n_trk_active, n_thr_active,
                            right_pulse, left_pulse, n_forward, level_next};
            r_out_known <= upd.known;
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out_data;
    assign m_axis_tuser[0] = r_out_known;

endmodule

FILE: bench/tmpc_checker.sv
// Result checker for the track motor PWM command controller: watches the request,
// result and register write channels, predicts every result and compares it.
// Depends on tmpc_pkg.
`timescale 1ns / 1ps

module tmpc_checker
    import tmpc_pkg::*;
#(
    parameter int COUNTER_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_req_valid,
    input  logic                  i_req_ready,
    // [7:0] cmd_type, [15:8] cmd_direction, [31:16] left_value, [47:32] right_value
    input  logic [47:0]           i_req_data,
    // [0] operation, [1] values_present
    input  logic [1:0]            i_req_user,
    input  logic                  i_res_valid,
    input  logic                  i_res_ready,
    // [3:0] pwm_levels, [7:4] forward_bits, [19:8] left_pulse, [31:20] right_pulse,
    // [32] thrusters_on, [33] tracks_on, [34] led_on
    input  logic [39:0]           i_res_data,
    // [0] command_known
    input  logic [0:0]            i_res_user,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] CASE_BIT   = 8'h20;
    localparam int                PRINT_CAP  = 100;

    typedef struct packed {
        logic [TRACKS-1:0]   levels;
        logic [TRACKS-1:0]   forward;
        logic [THRUST_W-1:0] left_pulse;
        logic [THRUST_W-1:0] right_pulse;
        logic                thrusters_on;
        logic                tracks_on;
        logic                led_on;
        logic                known;
    } t_outputs;

    // Register copies
    logic [PERIOD_W-1:0] period_ticks;
    logic [SPEED_W-1:0]  slow_duty;
    logic [SPEED_W-1:0]  fast_duty;
    logic [THRUST_W-1:0] stop_width;
    logic [THRUST_W-1:0] max_width;

    // Track and thruster state
    logic [SPEED_W-1:0]      duty [TRACKS];
    logic                    ahead [TRACKS];
    logic                    level [TRACKS];
    logic [COUNTER_BITS-1:0] elapsed [TRACKS];
    logic [THRUST_W-1:0]     left_width;
    logic [THRUST_W-1:0]     right_width;
    logic                    thrusters_running;
    logic                    tracks_running;
    logic                    led_lit;

    t_outputs expected_q[$];

    function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
        if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
            return c & ~CASE_BIT;
        end
        return c;
    endfunction

    // Clamp up to the stop width first, then down to the max width
    function automatic logic [THRUST_W-1:0] clamp_width(input logic signed [VALUE_W-1:0] raw);
        int v;
        v = int'(raw);
        if (v < int'(stop_width)) v = int'(stop_width);
        if (v > int'(max_width)) v = int'(max_width);
        return v[THRUST_W-1:0];
    endfunction

    task automatic set_tracks(input logic [SPEED_W-1:0] d0, d1, d2, d3, input logic fwd);
        duty[0] = d0;
        duty[1] = d1;
        duty[2] = d2;
        duty[3] = d3;
        for (int i = 0; i < TRACKS; i++) ahead[i] = fwd;
    endtask

    // Advance the software PWM of all four tracks by one tick
    task automatic advance_pwm();
        logic [63:0] high_t;
        logic [63:0] low_t;
        for (int i = 0; i < TRACKS; i++) begin
            if (duty[i] == '0) begin
                level[i]   = 1'b0;
                elapsed[i] = '0;
            end else begin
                high_t = (64'(period_ticks) * 64'(duty[i])) / 64'(DUTY_FULL);
                low_t  = 64'(period_ticks) - high_t;
                if (elapsed[i] != {COUNTER_BITS{1'b1}}) elapsed[i] = elapsed[i] + 1'b1;
                if (!level[i] && 64'(elapsed[i]) >= low_t) begin
                    level[i]   = 1'b1;
                    elapsed[i] = '0;
                end
                if (level[i] && 64'(elapsed[i]) >= high_t) begin
                    level[i]   = 1'b0;
                    elapsed[i] = '0;
                end
            end
        end
    endtask

    // Decode one two-letter command into the thruster and track state
    task automatic apply_command(input logic [CHAR_W-1:0] kind_ch, dir_ch, input logic with_values,
                                 input logic signed [VALUE_W-1:0] lv, rv, output logic known);
        logic [CHAR_W-1:0]  kind;
        logic [CHAR_W-1:0]  dir;
        logic [SPEED_W-1:0] sp;
        kind  = fold_case(kind_ch);
        dir   = fold_case(dir_ch);
        known = 1'b0;
        if (kind == CH_W) begin
            known             = 1'b1;
            thrusters_running = 1'b1;
            led_lit           = 1'b1;
            if (dir == CH_F) begin
                left_width  = with_values ? clamp_width(lv) : max_width;
                right_width = with_values ? clamp_width(rv) : max_width;
            end else if (dir == CH_L) begin
                left_width  = stop_width;
                right_width = max_width;
            end else if (dir == CH_R) begin
                left_width  = max_width;
                right_width = stop_width;
            end else begin
                left_width        = stop_width;
                right_width       = stop_width;
                thrusters_running = 1'b0;
                led_lit           = 1'b0;
            end
        end else if (kind == CH_T || kind == CH_U) begin
            sp             = (kind == CH_U) ? fast_duty : slow_duty;
            known          = 1'b1;
            tracks_running = 1'b1;
            led_lit        = 1'b1;
            case (dir)
                CH_F: set_tracks(sp, sp, sp, sp, 1'b1);
                CH_B: set_tracks(sp, sp, sp, sp, 1'b0);
                CH_L: set_tracks(slow_duty, sp, slow_duty, sp, 1'b1);
                CH_R: set_tracks(sp, slow_duty, sp, slow_duty, 1'b1);
                default: begin
                    for (int i = 0; i < TRACKS; i++) duty[i] = '0;
                    tracks_running = 1'b0;
                    led_lit        = 1'b0;
                end
            endcase
        end
    endtask

    function automatic t_outputs snapshot(input logic known);
        t_outputs r;
        for (int i = 0; i < TRACKS; i++) begin
            r.levels[i]  = level[i];
            r.forward[i] = ahead[i];
        end
        r.left_pulse   = thrusters_running ? left_width : stop_width;
        r.right_pulse  = thrusters_running ? right_width : stop_width;
        r.thrusters_on = thrusters_running;
        r.tracks_on    = tracks_running;
        r.led_on       = led_lit;
        r.known        = known;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want_v, seen_v);
        if (want_v !== seen_v) begin
            if (o_fail_count < PRINT_CAP) begin
                $display("%0t: %s expected %0d, got %0d", $time, name, want_v, seen_v);
            end
            o_fail_count++;
        end
    endtask

    // Track register writes, predict each request and compare each result
    always @(posedge i_clk) begin : watch
        t_outputs want;
        t_outputs seen;
        logic     known;
        if (!i_rst_n) begin
            period_ticks      = PERIOD_RST;
            slow_duty         = SLOW_RST;
            fast_duty         = FAST_RST;
            stop_width        = THRUST_STOP_RST;
            max_width         = THRUST_MAX_RST;
            for (int i = 0; i < TRACKS; i++) begin
                duty[i]    = '0;
                ahead[i]   = 1'b1;
                level[i]   = 1'b0;
                elapsed[i] = '0;
            end
            left_width        = THRUST_STOP_RST;
            right_width       = THRUST_STOP_RST;
            thrusters_running = 1'b0;
            tracks_running    = 1'b0;
            led_lit           = 1'b0;
            expected_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_PWM_PERIOD:  period_ticks = i_cfg_data[PERIOD_W-1:0];
                    REG_SLOW_SPEED:  slow_duty    = i_cfg_data[SPEED_W-1:0];
                    REG_FAST_SPEED:  fast_duty    = i_cfg_data[SPEED_W-1:0];
                    REG_THRUST_STOP: stop_width   = i_cfg_data[THRUST_W-1:0];
                    REG_THRUST_MAX:  max_width    = i_cfg_data[THRUST_W-1:0];
                    default: ;
                endcase
            end

            if (i_res_valid && i_res_ready) begin
                seen.levels       = i_res_data[3:0];
                seen.forward      = i_res_data[7:4];
                seen.left_pulse   = i_res_data[19:8];
                seen.right_pulse  = i_res_data[31:20];
                seen.thrusters_on = i_res_data[32];
                seen.tracks_on    = i_res_data[33];
                seen.led_on       = i_res_data[34];
                seen.known        = i_res_user[0];
                if (expected_q.size() == 0) begin
                    if (o_fail_count < PRINT_CAP) begin
                        $display("%0t: result with no request pending, expected none, got %h",
                                 $time, seen);
                    end
                    o_fail_count++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("pwm_levels", 32'(want.levels), 32'(seen.levels));
                    check_field("forward_bits", 32'(want.forward), 32'(seen.forward));
                    check_field("left_pulse", 32'(want.left_pulse), 32'(seen.left_pulse));
                    check_field("right_pulse", 32'(want.right_pulse), 32'(seen.right_pulse));
                    check_field("thrusters_on", 32'(want.thrusters_on),
                                32'(seen.thrusters_on));
                    check_field("tracks_on", 32'(want.tracks_on), 32'(seen.tracks_on));
                    check_field("led_on", 32'(want.led_on), 32'(seen.led_on));
                    check_field("command_known", 32'(want.known), 32'(seen.known));
                end
            end

            if (i_req_valid && i_req_ready) begin
                known = 1'b0;
                if (i_req_user[0] == OP_TICK) begin
                    advance_pwm();
                end else begin
                    apply_command(i_req_data[7:0], i_req_data[15:8], i_req_user[1],
                                  i_req_data[31:16], i_req_data[47:32], known);
                end
                expected_q.push_back(snapshot(known));
            end
        end
        o_pending = expected_q.size();
    end

endmodule

FILE: bench/tb_top.sv
// Testbench top for the track motor PWM command controller: clock, reset, request
// and register stimulus, result back-pressure and verdict. Depends on tmpc_pkg,
// tmpc_checker and the controller RTL.
`timescale 1ns / 1ps

module tb_top;
    import tmpc_pkg::*;

    localparam int                COUNTER_BITS = 16;
    localparam int                CYCLE_LIMIT  = 400000;
    localparam int                PHASES       = 10;
    localparam int                PHASE_ITEMS  = 170;
    localparam int                MAX_GAP      = 17;
    localparam logic [CHAR_W-1:0] CASE_BIT     = 8'h20;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [47:0]           s_axis_tdata = '0;
    logic [1:0]            s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [39:0]           m_axis_tdata;
    logic [0:0]            m_axis_tuser;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    int   mismatches;
    int   pending_results;
    int   cycle_count = 0;
    logic src_steady = 1'b0;
    logic sink_steady = 1'b0;

    always #2 i_clk = ~i_clk;

    track_motor_pwm_command_controller #(
        .COUNTER_BITS(COUNTER_BITS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    tmpc_checker #(
        .COUNTER_BITS(COUNTER_BITS)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .i_req_ready (s_axis_tready),
        .i_req_data  (s_axis_tdata),
        .i_req_user  (s_axis_tuser),
        .i_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .i_res_data  (m_axis_tdata),
        .i_res_user  (m_axis_tuser),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_fail_count(mismatches),
        .o_pending   (pending_results)
    );

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** track_motor_pwm_command_controller: FAILED **");
            $finish;
        end
    end

    // Stall the result channel for a random gap before each result, unless the sink is steady
    initial begin : result_sink
        int stall;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            stall = sink_steady ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            if ($urandom_range(0, 39) == 0) sink_steady = !sink_steady;
        end
    end

    function automatic logic [CHAR_W-1:0] mixed_case(input logic [CHAR_W-1:0] c);
        return $urandom_range(0, 1) ? (c | CASE_BIT) : c;
    endfunction

    // Half the widths near the clamp range (0 to 4200), the rest anywhere in 16 bits
    function automatic logic [VALUE_W-1:0] random_width();
        return $urandom_range(0, 1) ? VALUE_W'($urandom) : VALUE_W'($urandom_range(0, 4200));
    endfunction

    // Offer one request after a random gap and hold it until accepted
    task automatic send_request(input logic op, input logic [CHAR_W-1:0] kind, dir,
                                input logic with_values, input logic [VALUE_W-1:0] lv, rv);
        int gap;
        gap = src_steady ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {rv, lv, dir, kind};
        s_axis_tuser  <= {with_values, op};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic send_random_request(input int tick_pct);
        logic [CHAR_W-1:0] kind;
        logic [CHAR_W-1:0] dir;
        kind = CHAR_W'($urandom);
        dir  = CHAR_W'($urandom);
        if ($urandom_range(0, 99) < tick_pct) begin
            send_request(OP_TICK, kind, dir, 1'($urandom), random_width(), random_width());
        end else begin
            case ($urandom_range(0, 7))
                0, 1: kind = CH_W;
                2, 3: kind = CH_T;
                4, 5: kind = CH_U;
                default: ;
            endcase
            case ($urandom_range(0, 9))
                0, 1: dir = CH_F;
                2, 3: dir = CH_B;
                4, 5: dir = CH_L;
                6, 7: dir = CH_R;
                default: ;
            endcase
            send_request(OP_COMMAND, mixed_case(kind), mixed_case(dir), 1'($urandom),
                         random_width(), random_width());
        end
    endtask

    // Wait until every result is back, then let the pipeline drain
    task automatic wait_idle(input int settle);
        @(negedge i_clk);
        while (pending_results != 0) @(negedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    // Write all five registers back to back
    task automatic load_settings(input logic [PERIOD_W-1:0] period, input logic [SPEED_W-1:0] slow,
                                 input logic [SPEED_W-1:0] fast, input logic [THRUST_W-1:0] stop_w,
                                 input logic [THRUST_W-1:0] max_w);
        logic [CFG_IDX_W-1:0]  idx [5];
        logic [CFG_DATA_W-1:0] val [5];
        idx = '{REG_PWM_PERIOD, REG_SLOW_SPEED, REG_FAST_SPEED, REG_THRUST_STOP, REG_THRUST_MAX};
        val = '{period, CFG_DATA_W'(slow), CFG_DATA_W'(fast), CFG_DATA_W'(stop_w),
                CFG_DATA_W'(max_w)};
        i_cfg_valid <= 1'b1;
        for (int r = 0; r < 5; r++) begin
            i_cfg_index <= idx[r];
            i_cfg_data  <= val[r];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        logic [PERIOD_W-1:0] period;
        logic [SPEED_W-1:0]  slow;
        logic [SPEED_W-1:0]  fast;
        logic [THRUST_W-1:0] stop_w;
        logic [THRUST_W-1:0] max_w;
        int                  tick_pct;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: every command type and direction, case folding, clamp extremes, unknown types
        send_request(OP_TICK, 8'h00, 8'h00, 1'b0, 16'h0000, 16'h0000);
        send_request(OP_COMMAND, CH_W, CH_F, 1'b0, 16'h0000, 16'h0000);
        send_request(OP_COMMAND, CH_W, CH_F, 1'b1, 16'h8000, 16'h7FFF);
        send_request(OP_COMMAND, CH_W | CASE_BIT, CH_F | CASE_BIT, 1'b1, 16'd1500, 16'd1049);
        send_request(OP_COMMAND, CH_W, CH_F, 1'b1, 16'hFFFF, 16'd2001);
        send_request(OP_COMMAND, CH_W, CH_L, 1'b0, 16'h0000, 16'h0000);
        send_request(OP_COMMAND, CH_W | CASE_BIT, CH_R | CASE_BIT, 1'b1, 16'hFFFF, 16'hFFFF);
        send_request(OP_COMMAND, CH_W, CH_B, 1'b0, 16'h0000, 16'h0000);
        send_request(OP_COMMAND, CH_W, 8'h00, 1'b0, 16'h0000, 16'h0000);
        send_request(OP_COMMAND, CH_T, CH_F, 1'b0, 16'h0000, 16'h0000);
        send_request(OP_TICK, 8'hFF, 8'hFF, 1'b1, 16'hFFFF, 16'hFFFF);
        send_request(OP_COMMAND, CH_U | CASE_BIT, CH_B | CASE_BIT, 1'b0, 16'h0000, 16'h0000);
        send_request(OP_COMMAND, CH_T | CASE_BIT, CH_L | CASE_BIT, 1'b0, 16'h0000, 16'h0000);
        send_request(OP_COMMAND, CH_U, CH_R, 1'b0, 16'h0000, 16'h0000);
        send_request(OP_COMMAND, CH_U, CH_L, 1'b0, 16'h0000, 16'h0000);
        send_request(OP_COMMAND, CH_T, CH_R, 1'b0, 16'h0000, 16'h0000);
        send_request(OP_COMMAND, 8'hFF, CH_F, 1'b1, 16'hFFFF, 16'hFFFF);
        send_request(OP_COMMAND, 8'h00, CH_B, 1'b0, 16'h0000, 16'h0000);
        send_request(OP_TICK, 8'h00, 8'h00, 1'b0, 16'h0000, 16'h0000);
        send_request(OP_COMMAND, CH_U, 8'hFF, 1'b0, 16'h0000, 16'h0000);
        send_request(OP_TICK, 8'h00, 8'h00, 1'b0, 16'h0000, 16'h0000);

        // Random phases, each under its own register settings
        for (int p = 0; p < PHASES; p++) begin
            tick_pct = 70;
            if (p == 0) begin
                tick_pct = 40;
            end else begin
                wait_idle(4);
                period = PERIOD_W'($urandom_range(2, 48));
                slow   = SPEED_W'($urandom);
                fast   = SPEED_W'($urandom);
                stop_w = THRUST_W'($urandom_range(0, 2500));
                max_w  = THRUST_W'($urandom_range(1000, 4095));
                case (p)
                    1: begin
                        period = '0;
                        slow   = '0;
                        fast   = DUTY_FULL;
                        stop_w = '0;
                        max_w  = '1;
                    end
                    2: begin
                        period = 16'd1;
                        slow   = DUTY_FULL;
                        fast   = '0;
                        stop_w = '1;
                        max_w  = '0;
                    end
                    3: begin
                        period   = '1;
                        slow     = 8'd1;
                        fast     = 8'd254;
                        tick_pct = 50;
                    end
                    4: begin
                        stop_w = THRUST_W'($urandom);
                        max_w  = THRUST_W'($urandom);
                    end
                    default: ;
                endcase
                load_settings(period, slow, fast, stop_w, max_w);
            end
            src_steady = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < PHASE_ITEMS; n++) send_random_request(tick_pct);
            s_axis_tvalid <= 1'b0;
        end

        // Drain and give the verdict
        wait_idle(40);
        if (mismatches == 0) begin
            $display("** track_motor_pwm_command_controller: PASSED **");
        end else begin
            $display("** track_motor_pwm_command_controller: FAILED **");
        end
        $finish;
    end

endmodule
